/* rtl/core/i2c_wrts_pkg.sv */
// Types and constants shared by the I2C write-then-read sequencer and its checker.
package i2c_wrts_pkg;

    localparam int CNT_W   = 5;
    localparam int MAX_OUT = 16;

    typedef enum logic [2:0] {
        MODE_LOAD     = 3'd0,
        MODE_START    = 3'd1,
        MODE_POLL     = 3'd2,
        MODE_TX_REQ   = 3'd3,
        MODE_RX_BYTE  = 3'd4,
        MODE_COMPLETE = 3'd5,
        MODE_STOP     = 3'd6,
        MODE_ERROR    = 3'd7
    } mode_t;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_ISSUE   = 3'd1,
        ACT_TX      = 3'd2,
        ACT_DISABLE = 3'd3,
        ACT_READ    = 3'd4,
        ACT_DONE    = 3'd5,
        ACT_FAULT   = 3'd6
    } action_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_ACTIVE  = 2'd1,
        PH_STOPPED = 2'd2,
        PH_GOOD    = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_TX,
        SQ_STREAM
    } seq_state_t;

    typedef struct packed {
        action_t          action;
        logic [7:0]       target_address;
        logic [CNT_W-1:0] transfer_length;
        logic             is_write;
        logic             is_final_phase;
        logic [7:0]       out_byte;
        logic             last_item;
        logic             fatal;
        phase_t           phase_now;
    } out_word_t;

endpackage

/* rtl/core/i2c_write_read_transaction_sequencer.sv */
// Top level of the I2C write-then-read transaction sequencer.
//
//  channel | prefix | direction | carries
//  --------+--------+-----------+----------------------------------------------
//  events  | s_     | in        | one controller or host event per word
//  results | m_     | out       | one command or data word, last_item ends item
//
// Most events leave their single result in the output register. A transmit request
// passes through the SQ_TX state, as its byte comes from the buffer memory, whose
// read data is registered. A readout poll of N bytes streams them out at one buffer
// read a cycle while the output is not stalled, limited by the single memory read port.
// Reset (synchronous, aresetn low) returns the sequencer to idle with cleared counts.
// A stalled result only holds the output register; events wait until it is free.
module i2c_write_read_transaction_sequencer #(
    parameter int BUFFER_BYTES = 16,
    parameter int MAX_ERRORS   = 3
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_mode,
    input  logic [7:0] s_device_address,
    input  logic [4:0] s_send_count,
    input  logic [4:0] s_receive_count,
    input  logic [3:0] s_byte_index,
    input  logic [7:0] s_data_byte,
    input  logic       s_ms_pulse,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_action,
    output logic [7:0] m_target_address,
    output logic [4:0] m_transfer_length,
    output logic       m_is_write,
    output logic       m_is_final_phase,
    output logic [7:0] m_out_byte,
    output logic       m_last_item,
    output logic       m_fatal,
    output logic [1:0] m_phase_now
);

    localparam int ADDR_W = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
    localparam int OFF_W  = $clog2(BUFFER_BYTES + 1);
    localparam int CNT_W  = i2c_wrts_pkg::CNT_W;
    localparam int CMP_W  = (OFF_W > CNT_W) ? OFF_W : CNT_W;
    localparam int ERR_W  = $clog2(MAX_ERRORS + 1);

    // Buffer memory, written and read in one clocked block.
    logic [7:0]        data_mem [BUFFER_BYTES];
    logic [7:0]        rdata_reg;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    i2c_wrts_pkg::seq_state_t state_reg, state_next;
    i2c_wrts_pkg::phase_t     phase_reg, phase_next;
    logic [OFF_W-1:0]         offset_reg, offset_next;
    logic [7:0]               addr_reg, addr_next;
    logic [CNT_W-1:0]         send_reg, send_next;
    logic [CNT_W-1:0]         recv_reg, recv_next;
    logic [ERR_W-1:0]         err_reg, err_next;
    logic [2:0]               tout_reg, tout_next;
    logic [CNT_W-1:0]         strm_idx_reg, strm_idx_next;
    logic                     rd_pend_reg, rd_pend_next;
    logic                     rd_last_reg, rd_last_next;
    logic                     m_valid_reg, m_valid_next;
    i2c_wrts_pkg::out_word_t  out_reg, out_next;

    i2c_wrts_pkg::out_word_t  word;
    i2c_wrts_pkg::mode_t      mode;
    logic                     s_accept;
    logic                     to_read;
    logic                     load_out;
    logic                     issue;
    logic [CNT_W-1:0]         strm_total;
    logic [ERR_W-1:0]         err_plus;
    logic [2:0]               tout_dec;
    logic [OFF_W-1:0]         offset_inc;
    logic                     offset_full;

    // Timeout in milliseconds: 3 + (send + receive) / 10, held at 7.
    function automatic logic [2:0] timeout_init(input logic [CNT_W-1:0] snd,
                                                input logic [CNT_W-1:0] rcv);
        logic [CNT_W:0] sum;
        logic [2:0]     t;
        sum = {1'b0, snd} + {1'b0, rcv};
        if (sum >= (CNT_W+1)'(40)) begin
            t = 3'd7;
        end else if (sum >= (CNT_W+1)'(30)) begin
            t = 3'd6;
        end else if (sum >= (CNT_W+1)'(20)) begin
            t = 3'd5;
        end else if (sum >= (CNT_W+1)'(10)) begin
            t = 3'd4;
        end else begin
            t = 3'd3;
        end
        return t;
    endfunction

    // Transfer command: the write phase, or the final read when nothing is sent.
    function automatic i2c_wrts_pkg::out_word_t issue_word(input logic [7:0] adr,
                                                           input logic [CNT_W-1:0] snd,
                                                           input logic [CNT_W-1:0] rcv);
        i2c_wrts_pkg::out_word_t w;
        w                = '0;
        w.action         = i2c_wrts_pkg::ACT_ISSUE;
        w.target_address = adr;
        w.last_item      = 1'b1;
        if (snd == '0) begin
            w.transfer_length = rcv;
            w.is_write        = 1'b0;
            w.is_final_phase  = 1'b1;
        end else begin
            w.transfer_length = snd;
            w.is_write        = 1'b1;
            w.is_final_phase  = (rcv == '0);
        end
        return w;
    endfunction

    assign s_ready  = (state_reg == i2c_wrts_pkg::SQ_IDLE) && (!m_valid_reg || m_ready);
    assign s_accept = s_valid && s_ready;
    assign mode     = i2c_wrts_pkg::mode_t'(s_mode);

    assign strm_total  = (recv_reg > CNT_W'(i2c_wrts_pkg::MAX_OUT)) ?
                         CNT_W'(i2c_wrts_pkg::MAX_OUT) : recv_reg;
    assign err_plus    = err_reg + 1'b1;
    assign tout_dec    = (s_ms_pulse && (tout_reg != '0)) ? tout_reg - 1'b1 : tout_reg;
    assign offset_inc  = offset_reg + 1'b1;
    assign offset_full = CMP_W'(offset_reg) >= CMP_W'(BUFFER_BYTES);

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        offset_next   = offset_reg;
        addr_next     = addr_reg;
        send_next     = send_reg;
        recv_next     = recv_reg;
        err_next      = err_reg;
        tout_next     = tout_reg;
        strm_idx_next = strm_idx_reg;
        rd_pend_next  = rd_pend_reg;
        rd_last_next  = rd_last_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        out_next      = out_reg;
        wr_en         = 1'b0;
        wr_addr       = '0;
        rd_en         = 1'b0;
        rd_addr       = '0;
        to_read       = 1'b0;
        load_out      = 1'b0;
        issue         = 1'b0;
        word          = '0;
        word.action   = i2c_wrts_pkg::ACT_NONE;
        word.last_item = 1'b1;

        unique case (state_reg)
            i2c_wrts_pkg::SQ_IDLE: begin
                if (s_accept) begin
                    case (mode)
                        i2c_wrts_pkg::MODE_LOAD: begin
                            if (phase_reg == i2c_wrts_pkg::PH_IDLE &&
                                CMP_W'(s_byte_index) < CMP_W'(BUFFER_BYTES)) begin
                                wr_en   = 1'b1;
                                wr_addr = ADDR_W'(s_byte_index);
                            end else begin
                                word.action = i2c_wrts_pkg::ACT_FAULT;
                            end
                        end
                        i2c_wrts_pkg::MODE_START: begin
                            if (phase_reg != i2c_wrts_pkg::PH_IDLE ||
                                CMP_W'(s_send_count) > CMP_W'(BUFFER_BYTES) ||
                                CMP_W'(s_receive_count) > CMP_W'(BUFFER_BYTES)) begin
                                word.action = i2c_wrts_pkg::ACT_FAULT;
                            end else begin
                                addr_next   = s_device_address;
                                send_next   = s_send_count;
                                recv_next   = s_receive_count;
                                tout_next   = timeout_init(s_send_count, s_receive_count);
                                offset_next = '0;
                                phase_next  = i2c_wrts_pkg::PH_ACTIVE;
                                word        = issue_word(s_device_address, s_send_count,
                                                         s_receive_count);
                            end
                        end
                        i2c_wrts_pkg::MODE_POLL: begin
                            unique case (phase_reg)
                                i2c_wrts_pkg::PH_ACTIVE: begin
                                    tout_next = tout_dec;
                                    if (tout_dec == '0) begin
                                        word.action = i2c_wrts_pkg::ACT_DISABLE;
                                        if (err_plus >= ERR_W'(MAX_ERRORS)) begin
                                            err_next    = '0;
                                            offset_next = '0;
                                            phase_next  = i2c_wrts_pkg::PH_IDLE;
                                            word.fatal  = 1'b1;
                                        end else begin
                                            err_next   = err_plus;
                                            phase_next = i2c_wrts_pkg::PH_STOPPED;
                                        end
                                    end
                                end
                                i2c_wrts_pkg::PH_STOPPED: begin
                                    if (err_reg != '0) begin
                                        tout_next   = timeout_init(send_reg, recv_reg);
                                        offset_next = '0;
                                        phase_next  = i2c_wrts_pkg::PH_ACTIVE;
                                        word        = issue_word(addr_reg, send_reg, recv_reg);
                                    end else begin
                                        phase_next = i2c_wrts_pkg::PH_GOOD;
                                    end
                                end
                                i2c_wrts_pkg::PH_GOOD: begin
                                    phase_next = i2c_wrts_pkg::PH_IDLE;
                                    err_next   = '0;
                                    if (recv_reg == '0) begin
                                        word.action = i2c_wrts_pkg::ACT_DONE;
                                    end else begin
                                        to_read       = 1'b1;
                                        strm_idx_next = '0;
                                        rd_pend_next  = 1'b0;
                                        state_next    = i2c_wrts_pkg::SQ_STREAM;
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                        i2c_wrts_pkg::MODE_TX_REQ: begin
                            if (phase_reg == i2c_wrts_pkg::PH_ACTIVE) begin
                                if (send_reg == '0 || offset_full) begin
                                    word.action = i2c_wrts_pkg::ACT_FAULT;
                                end else begin
                                    to_read    = 1'b1;
                                    rd_en      = 1'b1;
                                    rd_addr    = ADDR_W'(offset_reg);
                                    state_next = i2c_wrts_pkg::SQ_TX;
                                    if (CMP_W'(offset_inc) >= CMP_W'(send_reg)) begin
                                        offset_next = '0;
                                    end else begin
                                        offset_next = offset_inc;
                                    end
                                end
                            end
                        end
                        i2c_wrts_pkg::MODE_RX_BYTE: begin
                            if (phase_reg == i2c_wrts_pkg::PH_ACTIVE) begin
                                if (offset_full) begin
                                    word.action = i2c_wrts_pkg::ACT_FAULT;
                                end else begin
                                    wr_en       = 1'b1;
                                    wr_addr     = ADDR_W'(offset_reg);
                                    offset_next = offset_inc;
                                end
                            end
                        end
                        i2c_wrts_pkg::MODE_COMPLETE: begin
                            if (phase_reg == i2c_wrts_pkg::PH_ACTIVE) begin
                                if (offset_reg == '0 && recv_reg != '0) begin
                                    word = issue_word(addr_reg, '0, recv_reg);
                                end else begin
                                    word.action = i2c_wrts_pkg::ACT_FAULT;
                                end
                            end
                        end
                        i2c_wrts_pkg::MODE_STOP: begin
                            if (phase_reg == i2c_wrts_pkg::PH_ACTIVE) begin
                                phase_next  = i2c_wrts_pkg::PH_STOPPED;
                                word.action = i2c_wrts_pkg::ACT_DISABLE;
                            end
                        end
                        default: begin
                            if (phase_reg == i2c_wrts_pkg::PH_ACTIVE) begin
                                word.action = i2c_wrts_pkg::ACT_DISABLE;
                                if (err_plus >= ERR_W'(MAX_ERRORS)) begin
                                    err_next    = '0;
                                    offset_next = '0;
                                    phase_next  = i2c_wrts_pkg::PH_IDLE;
                                    word.fatal  = 1'b1;
                                end else begin
                                    err_next   = err_plus;
                                    phase_next = i2c_wrts_pkg::PH_STOPPED;
                                end
                            end
                        end
                    endcase
                    word.phase_now = phase_next;
                    if (!to_read) begin
                        out_next     = word;
                        m_valid_next = 1'b1;
                    end
                end
            end
            i2c_wrts_pkg::SQ_TX: begin
                // The output register was free when the request was taken.
                word.action    = i2c_wrts_pkg::ACT_TX;
                word.out_byte  = rdata_reg;
                word.phase_now = phase_reg;
                out_next       = word;
                m_valid_next   = 1'b1;
                state_next     = i2c_wrts_pkg::SQ_IDLE;
            end
            i2c_wrts_pkg::SQ_STREAM: begin
                // A new read is issued only when the read register is empty or the word held in it moves on.
                load_out = rd_pend_reg && (!m_valid_reg || m_ready);
                issue    = (strm_idx_reg < strm_total) && (!rd_pend_reg || load_out);
                if (load_out) begin
                    word.action    = i2c_wrts_pkg::ACT_READ;
                    word.out_byte  = rdata_reg;
                    word.last_item = rd_last_reg;
                    word.phase_now = phase_reg;
                    out_next       = word;
                    m_valid_next   = 1'b1;
                    if (rd_last_reg) begin
                        state_next = i2c_wrts_pkg::SQ_IDLE;
                    end
                end
                if (issue) begin
                    rd_en         = 1'b1;
                    rd_addr       = ADDR_W'(strm_idx_reg);
                    rd_last_next  = (strm_idx_reg == strm_total - 1'b1);
                    strm_idx_next = strm_idx_reg + 1'b1;
                    rd_pend_next  = 1'b1;
                end else if (load_out) begin
                    rd_pend_next = 1'b0;
                end
            end
            default: begin
                state_next = i2c_wrts_pkg::SQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            data_mem[wr_addr] <= s_data_byte;
        end
        if (rd_en) begin
            rdata_reg <= data_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= i2c_wrts_pkg::SQ_IDLE;
            phase_reg    <= i2c_wrts_pkg::PH_IDLE;
            offset_reg   <= '0;
            addr_reg     <= '0;
            send_reg     <= '0;
            recv_reg     <= '0;
            err_reg      <= '0;
            tout_reg     <= '0;
            strm_idx_reg <= '0;
            rd_pend_reg  <= 1'b0;
            rd_last_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            offset_reg   <= offset_next;
            addr_reg     <= addr_next;
            send_reg     <= send_next;
            recv_reg     <= recv_next;
            err_reg      <= err_next;
            tout_reg     <= tout_next;
            strm_idx_reg <= strm_idx_next;
            rd_pend_reg  <= rd_pend_next;
            rd_last_reg  <= rd_last_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_action          = out_reg.action;
    assign m_target_address  = out_reg.target_address;
    assign m_transfer_length = out_reg.transfer_length;
    assign m_is_write        = out_reg.is_write;
    assign m_is_final_phase  = out_reg.is_final_phase;
    assign m_out_byte        = out_reg.out_byte;
    assign m_last_item       = out_reg.last_item;
    assign m_fatal           = out_reg.fatal;
    assign m_phase_now       = out_reg.phase_now;

endmodule

/* rtl/core/i2c_wrts_checker.sv */
// Port-level checker for the I2C write-then-read sequencer, with its bind.
module i2c_wrts_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_action,
    input logic [7:0] m_out_byte,
    input logic       m_last_item,
    input logic       m_fatal,
    input logic [1:0] m_phase_now
);

    // A stalled result word keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_action) && $stable(m_out_byte) &&
        $stable(m_last_item))
    else $error("result word changed while stalled");

    // An abort is always reported on a disable word that leaves the block idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_fatal |-> m_action == i2c_wrts_pkg::ACT_DISABLE &&
        m_phase_now == i2c_wrts_pkg::PH_IDLE)
    else $error("fatal flag on a word that is not an aborting disable");

    // Transfer commands are single-word results given while the transaction is active.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_action == i2c_wrts_pkg::ACT_ISSUE |->
        m_last_item && m_phase_now == i2c_wrts_pkg::PH_ACTIVE)
    else $error("transfer command in the wrong phase or not last");

    // Received data is only streamed out once the sequencer has returned to idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_action == i2c_wrts_pkg::ACT_READ |->
        m_phase_now == i2c_wrts_pkg::PH_IDLE && !m_fatal)
    else $error("read data word outside readout");

endmodule

bind i2c_write_read_transaction_sequencer i2c_wrts_checker u_i2c_wrts_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_action    (m_action),
    .m_out_byte  (m_out_byte),
    .m_last_item (m_last_item),
    .m_fatal     (m_fatal),
    .m_phase_now (m_phase_now)
);
